/* src/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Types, codes and helper functions shared by the prefetch tracker files.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int IdW   = 8;
  localparam int ConfW = 16;
  localparam int CntW  = 32;
  localparam int NetW  = 32;

  localparam int ExpertCount = 256;
  localparam logic [16:0] ExpertLimit = 17'(ExpertCount);

  localparam logic [ConfW-1:0] ThresholdReset = 16'd32768;

  typedef enum logic [1:0] {
    ACT_SPECULATE = 2'd0,
    ACT_CHECK     = 2'd1,
    ACT_ACCEPT    = 2'd2,
    ACT_ABORT     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SPEC = 2'd1,
    MODE_HIT  = 2'd2,
    MODE_MISS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_DECLINED = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef struct packed {
    action_e          action;
    logic [IdW-1:0]   first_id;
    logic             first_valid;
    logic [IdW-1:0]   second_id;
    logic             second_valid;
    logic [ConfW-1:0] confidence;
    logic             slot_index;
    logic [IdW-1:0]   actual_id;
    logic             actual_valid;
    logic             actual_last;
  } req_t;

  typedef struct packed {
    status_e                 status;
    mode_e                   mode;
    logic [CntW-1:0]         steal_count;
    logic [CntW-1:0]         hit_count;
    logic [CntW-1:0]         miss_count;
    logic [CntW-1:0]         abort_count;
    logic signed [NetW-1:0]  net_saved_ms;
    logic                    slot0_ready;
    logic                    slot1_ready;
  } rsp_t;

  function automatic logic id_ok(logic [IdW-1:0] id);
    return {9'd0, id} < ExpertLimit;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] value);
    return (&value) ? value : value + CntW'(1);
  endfunction

endpackage

/* src/spt_if.sv */
// ----------------------------------------------------------------------------
// spt_if
// Valid/ready channels of the prefetch tracker: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface spt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  first_id;
  logic        first_valid;
  logic [7:0]  second_id;
  logic        second_valid;
  logic [15:0] confidence;
  logic        slot_index;
  logic [7:0]  actual_id;
  logic        actual_valid;
  logic        actual_last;

  modport source (
    output valid, action, first_id, first_valid, second_id, second_valid,
           confidence, slot_index, actual_id, actual_valid, actual_last,
    input  ready
  );
  modport sink (
    input  valid, action, first_id, first_valid, second_id, second_valid,
           confidence, slot_index, actual_id, actual_valid, actual_last,
    output ready
  );
endinterface

interface spt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         mode;
  logic [31:0]        steal_count;
  logic [31:0]        hit_count;
  logic [31:0]        miss_count;
  logic [31:0]        abort_count;
  logic signed [31:0] net_saved_ms;
  logic               slot0_ready;
  logic               slot1_ready;

  modport source (
    output valid, status, mode, steal_count, hit_count, miss_count, abort_count,
           net_saved_ms, slot0_ready, slot1_ready,
    input  ready
  );
  modport sink (
    input  valid, status, mode, steal_count, hit_count, miss_count, abort_count,
           net_saved_ms, slot0_ready, slot1_ready,
    output ready
  );
endinterface

interface spt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/spt_in_stage.sv */
// ----------------------------------------------------------------------------
// spt_in_stage
// Input register that captures one request per cycle, as long as the core
// takes the held one, and hands it to the tracker core.
// ----------------------------------------------------------------------------
module spt_in_stage
  import spt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  spt_req_if.sink    req_i,
  output logic       item_valid_o,
  output req_t       item_o,
  input  logic       item_take_i
);

  logic valid_q;
  req_t req_q;

  assign req_i.ready  = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      valid_q <= 1'b1;
    end else if (item_take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.action       <= action_e'(req_i.action);
      req_q.first_id     <= req_i.first_id;
      req_q.first_valid  <= req_i.first_valid;
      req_q.second_id    <= req_i.second_id;
      req_q.second_valid <= req_i.second_valid;
      req_q.confidence   <= req_i.confidence;
      req_q.slot_index   <= req_i.slot_index;
      req_q.actual_id    <= req_i.actual_id;
      req_q.actual_valid <= req_i.actual_valid;
      req_q.actual_last  <= req_i.actual_last;
    end
  end

endmodule

/* src/spt_core.sv */
// ----------------------------------------------------------------------------
// spt_core
// Tracker state, combinational update for one request and the result
// register. Also holds the confidence threshold register.
// ----------------------------------------------------------------------------
module spt_core
  import spt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  req_t       item_i,
  output logic       item_take_o,
  spt_cfg_if.sink    cfg_i,
  spt_rsp_if.source  rsp_o
);

  logic [ConfW-1:0]        threshold_q;
  mode_e                   mode_q, mode_d;
  logic [IdW-1:0]          slot_id_q [2];
  logic [IdW-1:0]          slot_id_d [2];
  logic [1:0]              slot_valid_q, slot_valid_d;
  logic [1:0]              slot_ready_q, slot_ready_d;
  logic                    match_q, match_d;
  logic [CntW-1:0]         steal_q, steal_d;
  logic [CntW-1:0]         hit_q, hit_d;
  logic [CntW-1:0]         miss_q, miss_d;
  logic [CntW-1:0]         abort_q, abort_d;
  logic signed [NetW-1:0]  net_q, net_d;
  status_e                 status;
  logic                    out_valid_q;
  rsp_t                    rsp_q, rsp_d;
  logic                    hit_now;
  logic signed [NetW:0]    net_sum;

  assign item_take_o = item_valid_i && (!out_valid_q || rsp_o.ready);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    mode_d       = mode_q;
    slot_id_d    = slot_id_q;
    slot_valid_d = slot_valid_q;
    slot_ready_d = slot_ready_q;
    match_d      = match_q;
    steal_d      = steal_q;
    hit_d        = hit_q;
    miss_d       = miss_q;
    abort_d      = abort_q;
    net_d        = net_q;
    status       = ST_DONE;
    hit_now      = item_i.actual_valid && id_ok(item_i.actual_id) &&
                   ((slot_valid_q[0] && slot_ready_q[0] &&
                     slot_id_q[0] == item_i.actual_id) ||
                    (slot_valid_q[1] && slot_ready_q[1] &&
                     slot_id_q[1] == item_i.actual_id));
    net_sum      = {net_q[NetW-1], net_q} +
                   ((match_q || hit_now) ? 33'sd3 : -33'sd2);

    case (item_i.action)
      ACT_SPECULATE: begin
        if (mode_q != MODE_IDLE) begin
          status = ST_REJECTED;
        end else if (!item_i.first_valid || !id_ok(item_i.first_id) ||
                     item_i.confidence < threshold_q) begin
          status = ST_DECLINED;
        end else begin
          slot_id_d[0]    = item_i.first_id;
          slot_valid_d[0] = 1'b1;
          if (item_i.second_valid && id_ok(item_i.second_id)) begin
            slot_id_d[1]    = item_i.second_id;
            slot_valid_d[1] = 1'b1;
          end else begin
            slot_id_d[1]    = '0;
            slot_valid_d[1] = 1'b0;
          end
          slot_ready_d = 2'b11;
          match_d      = 1'b0;
          steal_d      = sat_inc(steal_q);
          mode_d       = MODE_SPEC;
        end
      end
      ACT_CHECK: begin
        if (mode_q != MODE_SPEC) begin
          status = ST_REJECTED;
        end else begin
          match_d = match_q || hit_now;
          if (item_i.actual_last) begin
            if (match_q || hit_now) begin
              mode_d = MODE_HIT;
              hit_d  = sat_inc(hit_q);
            end else begin
              mode_d = MODE_MISS;
              miss_d = sat_inc(miss_q);
            end
            if (net_sum[NetW] != net_sum[NetW-1]) begin
              net_d = net_sum[NetW] ? {1'b1, {(NetW-1){1'b0}}}
                                    : {1'b0, {(NetW-1){1'b1}}};
            end else begin
              net_d = net_sum[NetW-1:0];
            end
            match_d = 1'b0;
          end
        end
      end
      ACT_ACCEPT: begin
        slot_ready_d[item_i.slot_index] = 1'b0;
        mode_d = MODE_IDLE;
      end
      ACT_ABORT: begin
        if (mode_q == MODE_SPEC) begin
          abort_d = sat_inc(abort_q);
        end
        slot_id_d[0] = '0;
        slot_id_d[1] = '0;
        slot_valid_d = 2'b00;
        slot_ready_d = 2'b00;
        match_d      = 1'b0;
        mode_d       = MODE_IDLE;
      end
      default: begin
        status = ST_REJECTED;
      end
    endcase

    rsp_d.status       = status;
    rsp_d.mode         = mode_d;
    rsp_d.steal_count  = steal_d;
    rsp_d.hit_count    = hit_d;
    rsp_d.miss_count   = miss_d;
    rsp_d.abort_count  = abort_d;
    rsp_d.net_saved_ms = net_d;
    rsp_d.slot0_ready  = slot_ready_d[0];
    rsp_d.slot1_ready  = slot_ready_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= ThresholdReset;
      mode_q       <= MODE_IDLE;
      slot_id_q[0] <= '0;
      slot_id_q[1] <= '0;
      slot_valid_q <= 2'b00;
      slot_ready_q <= 2'b00;
      match_q      <= 1'b0;
      steal_q      <= '0;
      hit_q        <= '0;
      miss_q       <= '0;
      abort_q      <= '0;
      net_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        threshold_q <= cfg_i.data;
      end
      if (item_take_o) begin
        mode_q       <= mode_d;
        slot_id_q    <= slot_id_d;
        slot_valid_q <= slot_valid_d;
        slot_ready_q <= slot_ready_d;
        match_q      <= match_d;
        steal_q      <= steal_d;
        hit_q        <= hit_d;
        miss_q       <= miss_d;
        abort_q      <= abort_d;
        net_q        <= net_d;
        out_valid_q  <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.mode         = rsp_q.mode;
  assign rsp_o.steal_count  = rsp_q.steal_count;
  assign rsp_o.hit_count    = rsp_q.hit_count;
  assign rsp_o.miss_count   = rsp_q.miss_count;
  assign rsp_o.abort_count  = rsp_q.abort_count;
  assign rsp_o.net_saved_ms = rsp_q.net_saved_ms;
  assign rsp_o.slot0_ready  = rsp_q.slot0_ready;
  assign rsp_o.slot1_ready  = rsp_q.slot1_ready;

  // While speculating, the first slot always holds a ready expert.
  a_spec_slot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_SPEC |-> slot_valid_q[0] && slot_ready_q[0])
    else $error("speculating without a valid first slot");

  a_steal_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> steal_q >= $past(steal_q))
    else $error("steal counter decreased");

  a_abort_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && item_i.action == ACT_ABORT |=>
      mode_q == MODE_IDLE && slot_ready_q == 2'b00 && slot_valid_q == 2'b00)
    else $error("abort left slots or mode set");

  a_last_check_decides : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && item_i.action == ACT_CHECK && mode_q == MODE_SPEC &&
      item_i.actual_last |=> mode_q == MODE_HIT || mode_q == MODE_MISS)
    else $error("final check did not decide hit or miss");

endmodule

/* src/speculative_prefetch_tracker_unit.sv */
// ----------------------------------------------------------------------------
// speculative_prefetch_tracker_unit
// Tracks speculative prefetch of two predicted expert ids and keeps event
// counters and a saturating net-savings figure.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while results are taken, and
// returns exactly one result per request, held first in the input register
// and then in the result register. Each request is applied to the tracker
// state by a single pass of compare and counter logic, so a request sees the
// state left by the one accepted just before it. The threshold register is
// written through its own channel, which is always ready, and should only be
// changed while no request is in flight.
module speculative_prefetch_tracker_unit
  import spt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  spt_req_if.sink    req_i,
  spt_rsp_if.source  rsp_o,
  spt_cfg_if.sink    cfg_i
);

  logic item_valid;
  req_t item;
  logic item_take;

  spt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  spt_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .cfg_i        (cfg_i),
    .rsp_o        (rsp_o)
  );

endmodule

/* tb/speculative_prefetch_tracker_checker.sv */
// ----------------------------------------------------------------------------
// speculative_prefetch_tracker_checker
// Watches the request, result and threshold channels of the prefetch tracker.
// It keeps its own copy of the tracker state, works out the result of every
// accepted request and compares each accepted result, field by field, with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module speculative_prefetch_tracker_checker
  import spt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  spt_req_if   req_i,
  spt_rsp_if   rsp_i,
  spt_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint NetMax = 64'sd2147483647;
  localparam longint NetMin = -64'sd2147483648;

  logic [ConfW-1:0] threshold_q;
  mode_e            mode_q;
  logic [IdW-1:0]   slot_id_q [2];
  logic             slot_has_q [2];
  logic             slot_rdy_q [2];
  logic             match_q;
  logic [CntW-1:0]  steals_q;
  logic [CntW-1:0]  hits_q;
  logic [CntW-1:0]  misses_q;
  logic [CntW-1:0]  aborts_q;
  longint           net_q;

  rsp_t expected_results [$];
  req_t seen_req;
  rsp_t want;

  function automatic logic [CntW-1:0] bumped(logic [CntW-1:0] count);
    return (&count) ? count : count + 1'b1;
  endfunction

  function automatic logic expert_in_range(logic [IdW-1:0] id);
    return int'(id) < ExpertCount;
  endfunction

  function automatic void clear_tracker_slots();
    for (int s = 0; s < 2; s++) begin
      slot_id_q[s]  = '0;
      slot_has_q[s] = 1'b0;
      slot_rdy_q[s] = 1'b0;
    end
  endfunction

  function automatic rsp_t tracker_step(req_t r);
    rsp_t o;
    logic second_ok;
    o.status = ST_DONE;
    case (r.action)
      ACT_SPECULATE: begin
        if (mode_q != MODE_IDLE) begin
          o.status = ST_REJECTED;
        end else if (!r.first_valid || !expert_in_range(r.first_id) ||
                     r.confidence < threshold_q) begin
          o.status = ST_DECLINED;
        end else begin
          second_ok     = r.second_valid && expert_in_range(r.second_id);
          slot_id_q[0]  = r.first_id;
          slot_has_q[0] = 1'b1;
          slot_id_q[1]  = second_ok ? r.second_id : '0;
          slot_has_q[1] = second_ok;
          slot_rdy_q[0] = 1'b1;
          slot_rdy_q[1] = 1'b1;
          match_q       = 1'b0;
          steals_q      = bumped(steals_q);
          mode_q        = MODE_SPEC;
        end
      end
      ACT_CHECK: begin
        if (mode_q != MODE_SPEC) begin
          o.status = ST_REJECTED;
        end else begin
          if (r.actual_valid && expert_in_range(r.actual_id)) begin
            for (int s = 0; s < 2; s++) begin
              if (slot_has_q[s] && slot_rdy_q[s] && slot_id_q[s] == r.actual_id) begin
                match_q = 1'b1;
              end
            end
          end
          if (r.actual_last) begin
            if (match_q) begin
              mode_q = MODE_HIT;
              hits_q = bumped(hits_q);
              net_q  = (net_q > NetMax - 3) ? NetMax : net_q + 3;
            end else begin
              mode_q   = MODE_MISS;
              misses_q = bumped(misses_q);
              net_q    = (net_q < NetMin + 2) ? NetMin : net_q - 2;
            end
            match_q = 1'b0;
          end
        end
      end
      ACT_ACCEPT: begin
        slot_rdy_q[r.slot_index] = 1'b0;
        mode_q = MODE_IDLE;
      end
      default: begin
        if (mode_q == MODE_SPEC) begin
          aborts_q = bumped(aborts_q);
        end
        clear_tracker_slots();
        match_q = 1'b0;
        mode_q  = MODE_IDLE;
      end
    endcase
    o.mode         = mode_q;
    o.steal_count  = steals_q;
    o.hit_count    = hits_q;
    o.miss_count   = misses_q;
    o.abort_count  = aborts_q;
    o.net_saved_ms = net_q[NetW-1:0];
    o.slot0_ready  = slot_rdy_q[0];
    o.slot1_ready  = slot_rdy_q[1];
    return o;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v,
                                        logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  = ThresholdReset;
      mode_q       = MODE_IDLE;
      clear_tracker_slots();
      match_q      = 1'b0;
      steals_q     = '0;
      hits_q       = '0;
      misses_q     = '0;
      aborts_q     = '0;
      net_q        = 0;
      expected_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        threshold_q = cfg_i.data;
      end
      if (req_i.valid && req_i.ready) begin
        seen_req.action       = action_e'(req_i.action);
        seen_req.first_id     = req_i.first_id;
        seen_req.first_valid  = req_i.first_valid;
        seen_req.second_id    = req_i.second_id;
        seen_req.second_valid = req_i.second_valid;
        seen_req.confidence   = req_i.confidence;
        seen_req.slot_index   = req_i.slot_index;
        seen_req.actual_id    = req_i.actual_id;
        seen_req.actual_valid = req_i.actual_valid;
        seen_req.actual_last  = req_i.actual_last;
        expected_results.push_back(tracker_step(seen_req));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result arrived with no request outstanding", $time);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp_i.status));
          compare_field("mode", 32'(want.mode), 32'(rsp_i.mode));
          compare_field("steal_count", want.steal_count, rsp_i.steal_count);
          compare_field("hit_count", want.hit_count, rsp_i.hit_count);
          compare_field("miss_count", want.miss_count, rsp_i.miss_count);
          compare_field("abort_count", want.abort_count, rsp_i.abort_count);
          compare_field("net_saved_ms", want.net_saved_ms, rsp_i.net_saved_ms);
          compare_field("slot0_ready", 32'(want.slot0_ready), 32'(rsp_i.slot0_ready));
          compare_field("slot1_ready", 32'(want.slot1_ready), 32'(rsp_i.slot1_ready));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/speculative_prefetch_tracker_unit_tb.sv */
// ----------------------------------------------------------------------------
// speculative_prefetch_tracker_unit_tb
// Drives the prefetch tracker with a directed opening and then random
// speculation episodes and stray requests under several thresholds, with
// bursty requests and a stalling result side, and reports the verdict.
// ----------------------------------------------------------------------------
module speculative_prefetch_tracker_unit_tb;
  import spt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_PERIODIC} flow_e;

  localparam int PhaseItems = 250;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   burst_left;
  int   items_sent;
  int   phase_start;
  int   flow_left;
  int   flow_period;
  int   flow_tick;
  flow_e flow_style;
  logic [ConfW-1:0] threshold_now;
  logic [ConfW-1:0] phase_thresholds [6];

  spt_req_if req_ch ();
  spt_rsp_if rsp_ch ();
  spt_cfg_if cfg_ch ();

  speculative_prefetch_tracker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  speculative_prefetch_tracker_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (flow_left == 0) begin
      flow_style  = flow_e'($urandom_range(0, 2));
      flow_left   = $urandom_range(16, 96);
      flow_period = $urandom_range(2, 6);
    end
    flow_left--;
    flow_tick++;
    case (flow_style)
      FLOW_FREE: rsp_ch.ready <= 1'b1;
      FLOW_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
      default:   rsp_ch.ready <= (flow_tick % flow_period) == 0;
    endcase
  end

  function automatic req_t random_request();
    req_t r;
    r.action       = action_e'($urandom_range(0, 3));
    r.first_id     = 8'($urandom);
    r.first_valid  = 1'($urandom_range(0, 1));
    r.second_id    = 8'($urandom);
    r.second_valid = 1'($urandom_range(0, 1));
    r.confidence   = 16'($urandom);
    r.slot_index   = 1'($urandom_range(0, 1));
    r.actual_id    = 8'($urandom);
    r.actual_valid = 1'($urandom_range(0, 1));
    r.actual_last  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t speculate_req(logic [7:0] fid, logic fv, logic [7:0] sid,
                                         logic sv, logic [15:0] conf);
    req_t r;
    r              = random_request();
    r.action       = ACT_SPECULATE;
    r.first_id     = fid;
    r.first_valid  = fv;
    r.second_id    = sid;
    r.second_valid = sv;
    r.confidence   = conf;
    return r;
  endfunction

  function automatic req_t check_req(logic [7:0] aid, logic av, logic al);
    req_t r;
    r              = random_request();
    r.action       = ACT_CHECK;
    r.actual_id    = aid;
    r.actual_valid = av;
    r.actual_last  = al;
    return r;
  endfunction

  function automatic req_t control_req(action_e act, logic slot);
    req_t r;
    r            = random_request();
    r.action     = act;
    r.slot_index = slot;
    return r;
  endfunction

  function automatic logic [15:0] pick_confidence();
    case ($urandom_range(0, 5))
      0: return threshold_now;
      1: return (threshold_now == 0) ? 16'd0 : threshold_now - 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return threshold_now + 16'($urandom_range(0, 65535 - int'(threshold_now)));
    endcase
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
    end
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= r.action;
    req_ch.first_id     <= r.first_id;
    req_ch.first_valid  <= r.first_valid;
    req_ch.second_id    <= r.second_id;
    req_ch.second_valid <= r.second_valid;
    req_ch.confidence   <= r.confidence;
    req_ch.slot_index   <= r.slot_index;
    req_ch.actual_id    <= r.actual_id;
    req_ch.actual_valid <= r.actual_valid;
    req_ch.actual_last  <= r.actual_last;
    do @(posedge clk_i); while (!req_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    threshold_now = value;
  endtask

  task automatic run_episode();
    req_t r;
    int checks;
    logic [7:0] pred0;
    logic [7:0] pred1;
    r = speculate_req(8'($urandom), ($urandom_range(0, 7) != 0), 8'($urandom),
                      ($urandom_range(0, 3) != 0), pick_confidence());
    pred0 = r.first_id;
    pred1 = r.second_id;
    send_request(r);
    checks = $urandom_range(1, 5);
    for (int i = 0; i < checks; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        send_request(control_req(ACT_ABORT, 1'($urandom_range(0, 1))));
        return;
      end
      r = check_req(8'($urandom), ($urandom_range(0, 7) != 0), (i == checks - 1));
      case ($urandom_range(0, 3))
        0: r.actual_id = pred0;
        1: r.actual_id = pred1;
        default: ;
      endcase
      send_request(r);
    end
    if ($urandom_range(0, 2) != 0) begin
      send_request(control_req(ACT_ACCEPT, 1'($urandom_range(0, 1))));
    end else begin
      send_request(control_req(ACT_ABORT, 1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.action       = ACT_SPECULATE;
    req_ch.first_id     = '0;
    req_ch.first_valid  = 1'b0;
    req_ch.second_id    = '0;
    req_ch.second_valid = 1'b0;
    req_ch.confidence   = '0;
    req_ch.slot_index   = 1'b0;
    req_ch.actual_id    = '0;
    req_ch.actual_valid = 1'b0;
    req_ch.actual_last  = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    burst_left          = 0;
    items_sent          = 0;
    flow_left           = 0;
    flow_tick           = 0;
    threshold_now       = ThresholdReset;
    phase_thresholds    = '{16'd0, 16'hFFFF, ThresholdReset, 16'($urandom),
                            16'($urandom), 16'd1};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(check_req(8'd0, 1'b1, 1'b1));
    send_request(control_req(ACT_ACCEPT, 1'b1));
    send_request(control_req(ACT_ABORT, 1'b0));
    send_request(speculate_req(8'd3, 1'b0, 8'd4, 1'b1, 16'hFFFF));
    send_request(speculate_req(8'd3, 1'b1, 8'd4, 1'b1, ThresholdReset - 16'd1));
    send_request(speculate_req(8'd255, 1'b1, 8'd0, 1'b1, ThresholdReset));
    send_request(speculate_req(8'd7, 1'b1, 8'd8, 1'b1, 16'hFFFF));
    send_request(check_req(8'd0, 1'b1, 1'b0));
    send_request(check_req(8'd7, 1'b1, 1'b1));
    send_request(check_req(8'd255, 1'b1, 1'b1));
    send_request(control_req(ACT_ACCEPT, 1'b0));
    send_request(speculate_req(8'd0, 1'b1, 8'd255, 1'b0, 16'hFFFF));
    send_request(check_req(8'd0, 1'b0, 1'b1));
    send_request(control_req(ACT_ABORT, 1'b1));
    send_request(speculate_req(8'd10, 1'b1, 8'd20, 1'b1, 16'd40000));
    send_request(control_req(ACT_ABORT, 1'b0));
    send_request(speculate_req(8'd5, 1'b1, 8'd6, 1'b1, 16'd50000));
    send_request(control_req(ACT_ACCEPT, 1'b1));
    send_request(speculate_req(8'd1, 1'b1, 8'd2, 1'b1, 16'hFFFF));
    send_request(check_req(8'd2, 1'b1, 1'b1));
    send_request(control_req(ACT_ACCEPT, 1'b1));
    send_request(speculate_req(8'd3, 1'b1, 8'd4, 1'b1, 16'hFFFF));
    send_request(check_req(8'd9, 1'b1, 1'b0));
    send_request(check_req(8'd255, 1'b1, 1'b1));
    send_request(control_req(ACT_ABORT, 1'b0));

    foreach (phase_thresholds[p]) begin
      wait_drained();
      write_threshold(phase_thresholds[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          send_request(random_request());
        end else begin
          run_episode();
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
src/spt_pkg.sv
src/spt_if.sv
src/spt_in_stage.sv
src/spt_core.sv
src/speculative_prefetch_tracker_unit.sv
tb/speculative_prefetch_tracker_checker.sv
tb/speculative_prefetch_tracker_unit_tb.sv
